/* rtl/core/pkbed_pkg.sv */
// shared types, codes and helpers for the prefix key block entry decoder
// no dependencies; used by every module under rtl/core
package pkbed_pkg;

    // lengths run from zero up to the largest key bound (64)
    localparam int LEN_W = 7;

    localparam logic [1:0] KIND_KEY   = 2'd0;
    localparam logic [1:0] KIND_VALUE = 2'd1;
    localparam logic [1:0] KIND_NONE  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_HDR  = 2'd1;
    localparam logic [1:0] ST_CUT_BODY = 2'd2;
    localparam logic [1:0] ST_KEY_LONG = 2'd3;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] byte_kind;
        logic       entry_end;
        logic [1:0] status;
        logic       last_of_run;
    } result_t;

    // prefix replay request from the parser to the key store
    typedef struct packed {
        logic             valid;
        logic [LEN_W-1:0] count;
        logic [LEN_W-1:0] old_len;
        logic             entry_done;
    } replay_req_t;

    // key byte write from the parser
    typedef struct packed {
        logic             valid;
        logic [LEN_W-1:0] addr;
        logic [7:0]       data;
    } key_wr_t;

    function automatic result_t make_marker(input logic [1:0] st, input logic ent_end);
        result_t r;
        r.out_byte    = 8'd0;
        r.byte_kind   = KIND_NONE;
        r.entry_end   = ent_end;
        r.status      = st;
        r.last_of_run = 1'b1;
        return r;
    endfunction

endpackage

/* rtl/core/prefix_key_block_entry_decoder_unit.sv */
// top level of the prefix key block entry decoder: stream ports and output register
// depends on pkbed_pkg, pkbed_parser, pkbed_key_store
// output: each result is registered and is on the output in the cycle after its byte is accepted;
//   a completed header with a shared prefix of n bytes replays them from the key store, each
//   prefix byte passing through the RS_READ and RS_PUSH states before the output register
// throughput: one byte per cycle while the output drains and no replay runs; a header end
//   with a shared prefix blocks input until the read-then-push loop on the key memory port ends
// reset: rst_n asynchronous, clears parse state, key length, halt flag, replay state and the
//   output valid flag; the key memory holds garbage until entries are written
module prefix_key_block_entry_decoder_unit #(
    parameter int KEY_MAX = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,  // [7:0] data_byte
    input  logic       s_axis_tuser,  // [0] block_start
    input  logic       s_axis_tlast,  // data_end
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,  // [7:0] out_byte
    output logic [4:0] m_axis_tuser,  // [1:0] byte_kind, [3:2] status, [4] last_of_run
    output logic       m_axis_tlast   // entry_end
);

    logic                   in_fire;
    logic                   out_free;
    logic                   busy;

    pkbed_pkg::result_t     par_res;
    logic                   par_res_valid;
    pkbed_pkg::replay_req_t rep_req;
    pkbed_pkg::key_wr_t     kwr;
    pkbed_pkg::result_t     rep_res;
    logic                   rep_res_valid;

    logic                   out_valid_reg;
    pkbed_pkg::result_t     out_item_reg;

    // output slot is free when empty or being taken this cycle
    assign out_free      = !out_valid_reg || m_axis_tready;
    // one item at a time: no input while a prefix replay runs
    assign s_axis_tready = !busy && out_free;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    pkbed_parser #(
        .KEY_MAX (KEY_MAX)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .data_byte   (s_axis_tdata),
        .block_start (s_axis_tuser),
        .data_end    (s_axis_tlast),
        .res         (par_res),
        .res_valid   (par_res_valid),
        .req         (rep_req),
        .kwr         (kwr)
    );

    pkbed_key_store #(
        .KEY_MAX (KEY_MAX)
    ) u_key_store (
        .clk           (clk),
        .rst_n         (rst_n),
        .kwr           (kwr),
        .req           (rep_req),
        .out_free      (out_free),
        .rep_res       (rep_res),
        .rep_res_valid (rep_res_valid),
        .busy          (busy)
    );

    // single output register, loaded from the parser or from the replay
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (par_res_valid || rep_res_valid)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (rep_res_valid)
            out_item_reg <= rep_res;
        else if (par_res_valid)
            out_item_reg <= par_res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_item_reg.out_byte;
    assign m_axis_tuser  = {out_item_reg.last_of_run, out_item_reg.status,
                            out_item_reg.byte_kind};
    assign m_axis_tlast  = out_item_reg.entry_end;

    // the parser and the replay never load the output register together
    a_single_loader: assert property (@(posedge clk) disable iff (!rst_n)
        !(par_res_valid && rep_res_valid))
        else $error("parser and replay load the output in the same cycle");

    // a replay push never overwrites a result not yet taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        rep_res_valid |-> out_free)
        else $error("replay result overwrites a pending output");

    // a replay request comes from an accepted header byte with no direct result
    a_req_alone: assert property (@(posedge clk) disable iff (!rst_n)
        rep_req.valid |-> (in_fire && !par_res_valid && !busy))
        else $error("replay request without a clean header end");

    // once a replay starts, input stays blocked in the next cycle
    a_replay_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        rep_req.valid |=> !s_axis_tready)
        else $error("input accepted during prefix replay");

endmodule

/* rtl/core/pkbed_parser.sv */
// entry header and body parser: varint decode, length checks, key byte writes
// depends on pkbed_pkg
module pkbed_parser #(
    parameter int KEY_MAX = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_fire,
    input  logic [7:0]            data_byte,
    input  logic                  block_start,
    input  logic                  data_end,
    output pkbed_pkg::result_t    res,
    output logic                  res_valid,
    output pkbed_pkg::replay_req_t req,
    output pkbed_pkg::key_wr_t    kwr
);

    localparam int LW = pkbed_pkg::LEN_W;

    typedef enum logic [2:0] {
        PH_SHARED   = 3'd0,
        PH_UNSHARED = 3'd1,
        PH_VLEN     = 3'd2,
        PH_KEY      = 3'd3,
        PH_VALUE    = 3'd4
    } phase_t;

    phase_t        phase_reg, phase_next;
    logic [31:0]   accum_reg, accum_next;
    logic [2:0]    nbytes_reg, nbytes_next;
    logic [31:0]   shared_reg, shared_next;
    logic [31:0]   uns_reg, uns_next;
    logic [31:0]   vlen_reg, vlen_next;
    logic [LW-1:0] klen_reg, klen_next;
    logic          halted_reg, halted_next;

    always_comb
    begin
        phase_t      ph;
        logic [31:0] acc;
        logic [2:0]  nb;
        logic [31:0] shr;
        logic [31:0] uns;
        logic [31:0] vl;
        logic [LW-1:0] kl;
        logic        hlt;
        logic [31:0] contrib;
        logic [31:0] acc_new;
        logic [32:0] key_sum;
        logic        done;

        // block start clears everything before the byte is taken
        if (block_start)
        begin
            ph  = PH_SHARED;
            acc = '0;
            nb  = '0;
            shr = '0;
            uns = '0;
            vl  = '0;
            kl  = '0;
            hlt = 1'b0;
        end
        else
        begin
            ph  = phase_reg;
            acc = accum_reg;
            nb  = nbytes_reg;
            shr = shared_reg;
            uns = uns_reg;
            vl  = vlen_reg;
            kl  = klen_reg;
            hlt = halted_reg;
        end

        case (nb)
            3'd0:    contrib = {25'd0, data_byte[6:0]};
            3'd1:    contrib = {18'd0, data_byte[6:0], 7'd0};
            3'd2:    contrib = {11'd0, data_byte[6:0], 14'd0};
            3'd3:    contrib = {4'd0, data_byte[6:0], 21'd0};
            3'd4:    contrib = {data_byte[3:0], 28'd0};
            default: contrib = '0;
        endcase
        acc_new = acc | contrib;
        key_sum = {1'b0, shr} + {1'b0, uns};
        done    = 1'b0;

        phase_next  = phase_reg;
        accum_next  = accum_reg;
        nbytes_next = nbytes_reg;
        shared_next = shared_reg;
        uns_next    = uns_reg;
        vlen_next   = vlen_reg;
        klen_next   = klen_reg;
        halted_next = halted_reg;
        res         = '0;
        res_valid   = 1'b0;
        req         = '0;
        kwr         = '0;

        if (in_fire)
        begin
            phase_next  = ph;
            accum_next  = acc;
            nbytes_next = nb;
            shared_next = shr;
            uns_next    = uns;
            vlen_next   = vl;
            klen_next   = kl;
            halted_next = hlt;

            if (!hlt)
            begin
                case (ph)
                    PH_SHARED, PH_UNSHARED, PH_VLEN:
                    begin
                        if (nb > 3'd4)
                        begin
                            res = pkbed_pkg::make_marker(pkbed_pkg::ST_BAD_HDR, 1'b0);
                            res_valid   = 1'b1;
                            halted_next = 1'b1;
                        end
                        else if (data_byte[7])
                        begin
                            accum_next  = acc_new;
                            nbytes_next = nb + 3'd1;
                            // fifth byte still continuing, or cut mid varint
                            if (nb == 3'd4 || data_end)
                            begin
                                res = pkbed_pkg::make_marker(pkbed_pkg::ST_BAD_HDR, 1'b0);
                                res_valid   = 1'b1;
                                halted_next = 1'b1;
                            end
                        end
                        else
                        begin
                            accum_next  = '0;
                            nbytes_next = '0;
                            if (ph == PH_SHARED || ph == PH_UNSHARED)
                            begin
                                if (ph == PH_SHARED)
                                begin
                                    shared_next = acc_new;
                                    phase_next  = PH_UNSHARED;
                                end
                                else
                                begin
                                    uns_next   = acc_new;
                                    phase_next = PH_VLEN;
                                end
                                if (data_end)
                                begin
                                    res = pkbed_pkg::make_marker(pkbed_pkg::ST_BAD_HDR, 1'b0);
                                    res_valid   = 1'b1;
                                    halted_next = 1'b1;
                                end
                            end
                            else
                            begin
                                vlen_next = acc_new;
                                if (key_sum > 33'(KEY_MAX))
                                begin
                                    res = pkbed_pkg::make_marker(pkbed_pkg::ST_KEY_LONG, 1'b0);
                                    res_valid   = 1'b1;
                                    halted_next = 1'b1;
                                end
                                else if (data_end && (uns != '0 || acc_new != '0))
                                begin
                                    res = pkbed_pkg::make_marker(pkbed_pkg::ST_CUT_BODY, 1'b0);
                                    res_valid   = 1'b1;
                                    halted_next = 1'b1;
                                end
                                else
                                begin
                                    // header complete: replay any shared prefix, then body
                                    done      = (uns == '0) && (acc_new == '0);
                                    klen_next = shr[LW-1:0];
                                    if (shr != '0)
                                    begin
                                        req.valid      = 1'b1;
                                        req.count      = shr[LW-1:0];
                                        req.old_len    = kl;
                                        req.entry_done = done;
                                    end
                                    else if (done)
                                    begin
                                        res = pkbed_pkg::make_marker(pkbed_pkg::ST_OK, 1'b1);
                                        res_valid = 1'b1;
                                    end
                                    if (uns != '0)
                                        phase_next = PH_KEY;
                                    else if (acc_new != '0)
                                        phase_next = PH_VALUE;
                                    else
                                        phase_next = PH_SHARED;
                                    if (data_end && done)
                                        halted_next = 1'b1;
                                end
                            end
                        end
                    end
                    PH_KEY:
                    begin
                        done = (uns <= 32'd1) && (vl == '0);
                        if (data_end && !done)
                        begin
                            res = pkbed_pkg::make_marker(pkbed_pkg::ST_CUT_BODY, 1'b0);
                            res_valid   = 1'b1;
                            halted_next = 1'b1;
                        end
                        else
                        begin
                            if (kl < LW'(KEY_MAX))
                            begin
                                kwr.valid = 1'b1;
                                kwr.addr  = kl;
                                kwr.data  = data_byte;
                                klen_next = kl + LW'(1);
                            end
                            uns_next = (uns != '0) ? uns - 32'd1 : '0;
                            res.out_byte    = data_byte;
                            res.byte_kind   = pkbed_pkg::KIND_KEY;
                            res.entry_end   = done;
                            res.status      = pkbed_pkg::ST_OK;
                            res.last_of_run = 1'b1;
                            res_valid       = 1'b1;
                            if (uns <= 32'd1)
                                phase_next = done ? PH_SHARED : PH_VALUE;
                            if (data_end)
                                halted_next = 1'b1;
                        end
                    end
                    PH_VALUE:
                    begin
                        done = (vl <= 32'd1);
                        if (data_end && !done)
                        begin
                            res = pkbed_pkg::make_marker(pkbed_pkg::ST_CUT_BODY, 1'b0);
                            res_valid   = 1'b1;
                            halted_next = 1'b1;
                        end
                        else
                        begin
                            vlen_next = (vl != '0) ? vl - 32'd1 : '0;
                            res.out_byte    = data_byte;
                            res.byte_kind   = pkbed_pkg::KIND_VALUE;
                            res.entry_end   = done;
                            res.status      = pkbed_pkg::ST_OK;
                            res.last_of_run = 1'b1;
                            res_valid       = 1'b1;
                            if (done)
                                phase_next = PH_SHARED;
                            if (data_end)
                                halted_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next  = PH_SHARED;
                        accum_next  = '0;
                        nbytes_next = '0;
                        shared_next = '0;
                        uns_next    = '0;
                        vlen_next   = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SHARED;
            accum_reg  <= '0;
            nbytes_reg <= '0;
            shared_reg <= '0;
            uns_reg    <= '0;
            vlen_reg   <= '0;
            klen_reg   <= '0;
            halted_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            accum_reg  <= accum_next;
            nbytes_reg <= nbytes_next;
            shared_reg <= shared_next;
            uns_reg    <= uns_next;
            vlen_reg   <= vlen_next;
            klen_reg   <= klen_next;
            halted_reg <= halted_next;
        end
    end

endmodule

/* rtl/core/pkbed_key_store.sv */
// previous-key memory and shared-prefix replay sequencer
// depends on pkbed_pkg
module pkbed_key_store #(
    parameter int KEY_MAX = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pkbed_pkg::key_wr_t     kwr,
    input  pkbed_pkg::replay_req_t req,
    input  logic                   out_free,
    output pkbed_pkg::result_t     rep_res,
    output logic                   rep_res_valid,
    output logic                   busy
);

    localparam int LW = pkbed_pkg::LEN_W;
    localparam int AW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

    typedef enum logic [1:0] {
        RS_IDLE,
        RS_READ,
        RS_PUSH
    } rstate_t;

    rstate_t       state_reg;
    logic [LW-1:0] idx_reg;
    logic [LW-1:0] cnt_reg;
    logic [LW-1:0] old_reg;
    logic          done_reg;

    logic [7:0]    mem [KEY_MAX];
    logic [7:0]    rd_data_reg;

    logic          push;
    logic          last;
    logic          pad;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;

    assign push = (state_reg == RS_PUSH) && out_free;
    assign last = (idx_reg + LW'(1)) == cnt_reg;
    // positions past the old key are padding and become zero
    assign pad  = idx_reg >= old_reg;

    always_comb
    begin
        if (kwr.valid)
        begin
            wr_en   = 1'b1;
            wr_addr = kwr.addr[AW-1:0];
            wr_data = kwr.data;
        end
        else
        begin
            wr_en   = push && pad;
            wr_addr = idx_reg[AW-1:0];
            wr_data = 8'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[idx_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RS_IDLE;
            idx_reg   <= '0;
            cnt_reg   <= '0;
            old_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                RS_IDLE:
                begin
                    if (req.valid)
                    begin
                        idx_reg   <= '0;
                        cnt_reg   <= req.count;
                        old_reg   <= req.old_len;
                        done_reg  <= req.entry_done;
                        state_reg <= RS_READ;
                    end
                end
                RS_READ:
                    state_reg <= RS_PUSH;
                RS_PUSH:
                begin
                    if (push)
                    begin
                        idx_reg   <= idx_reg + LW'(1);
                        state_reg <= last ? RS_IDLE : RS_READ;
                    end
                end
                default:
                    state_reg <= RS_IDLE;
            endcase
        end
    end

    always_comb
    begin
        rep_res.out_byte    = pad ? 8'd0 : rd_data_reg;
        rep_res.byte_kind   = pkbed_pkg::KIND_KEY;
        rep_res.entry_end   = last && done_reg;
        rep_res.status      = pkbed_pkg::ST_OK;
        rep_res.last_of_run = last;
    end

    assign rep_res_valid = push;
    assign busy          = state_reg != RS_IDLE;

endmodule
